// ===== hdl/euler_rotation_matrix_unit_defines.svh =====
// assertion macros for the euler rotation matrix unit
// expects clk and rst in the scope of each use
`ifndef EULER_ROTATION_MATRIX_UNIT_DEFINES_SVH
`define EULER_ROTATION_MATRIX_UNIT_DEFINES_SVH

// same-cycle implication
`define ERM_ASSERT_IMPL(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication
`define ERM_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== hdl/erm_pkg.sv =====
// shared types and constants for the euler rotation matrix unit
// no dependencies
package erm_pkg;

  typedef struct packed {
    logic [15:0] angle_x;
    logic [15:0] angle_y;
    logic [15:0] angle_z;
  } erm_in_t;

  typedef struct packed {
    logic signed [15:0] r0c0;
    logic signed [15:0] r0c1;
    logic signed [15:0] r0c2;
    logic signed [15:0] r1c0;
    logic signed [15:0] r1c1;
    logic signed [15:0] r1c2;
    logic signed [15:0] r2c0;
    logic signed [15:0] r2c1;
    logic signed [15:0] r2c2;
  } erm_out_t;

  typedef enum logic [2:0] {
    FS_ANGLE,
    FS_SQUARE,
    FS_TERM,
    FS_RECIP,
    FS_REMAIN,
    FS_FIX,
    FS_ROUND,
    FS_DONE
  } fill_state_t;

  typedef struct packed {
    logic wr_en;
    logic done;
  } fill_ctl_t;

  localparam int QUEUE_DEPTH = 4;
  localparam int QPTR_BITS   = $clog2(QUEUE_DEPTH);
  localparam int QCOUNT_BITS = $clog2(QUEUE_DEPTH + 1);

  typedef struct packed {
    logic                   nonempty;
    logic [QCOUNT_BITS-1:0] count;
  } queue_stat_t;

  // pi/2 in Q30
  localparam logic [30:0] HPI_Q30 = 31'd1686629713;

  // quadrant codes taken from the top two phase bits
  localparam logic [1:0] QD_FIRST  = 2'd0;
  localparam logic [1:0] QD_SECOND = 2'd1;
  localparam logic [1:0] QD_THIRD  = 2'd2;
  localparam logic [1:0] QD_FOURTH = 2'd3;

  // (2n)(2n+1) for series term n = idx + 1
  function automatic logic [8:0] divisor(input logic [2:0] idx);
    logic [8:0] d;
    case (idx)
      3'd0:    d = 9'd6;
      3'd1:    d = 9'd20;
      3'd2:    d = 9'd42;
      3'd3:    d = 9'd72;
      3'd4:    d = 9'd110;
      3'd5:    d = 9'd156;
      3'd6:    d = 9'd210;
      default: d = 9'd272;
    endcase
    return d;
  endfunction

  // floor(2^32 / divisor), never above the true reciprocal
  function automatic logic [31:0] recip(input logic [2:0] idx);
    logic [31:0] m;
    case (idx)
      3'd0:    m = 32'd715827882;
      3'd1:    m = 32'd214748364;
      3'd2:    m = 32'd102261126;
      3'd3:    m = 32'd59652323;
      3'd4:    m = 32'd39045157;
      3'd5:    m = 32'd27531841;
      3'd6:    m = 32'd20452225;
      default: m = 32'd15790320;
    endcase
    return m;
  endfunction

endpackage

// ===== hdl/euler_rotation_matrix_unit.sv =====
// euler rotation matrix R = Rz*Ry*Rx from three phase words, Q1.FRAC_BITS entries
// one transaction per cycle sustained while out_ready is high
// throughput set by the two-read-port sine memory per axis and the pipelined multipliers
// after reset the sine memories are filled by a multi-cycle series evaluator:
// 2^(ANGLE_BITS-2) entries, in_ready low until done
// reset is synchronous, active high; depends on erm_pkg and the defines header
`include "euler_rotation_matrix_unit_defines.svh"

module euler_rotation_matrix_unit #(
  parameter int ANGLE_BITS = 16,
  parameter int FRAC_BITS  = 14
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  output logic               in_ready,
  input  erm_pkg::erm_in_t   in_data,
  output logic               out_valid,
  input  logic               out_ready,
  output erm_pkg::erm_out_t  out_data
);
  import erm_pkg::*;

  localparam int W  = FRAC_BITS + 2;
  localparam int DW = 6 * W;
  localparam logic [QCOUNT_BITS-1:0] QFULL = QCOUNT_BITS'(QUEUE_DEPTH);

  fill_ctl_t              fill;
  logic [ANGLE_BITS-3:0]  wr_addr;
  logic [FRAC_BITS:0]     wr_data;
  queue_stat_t            q_stat;
  logic                   push;
  logic [DW-1:0]          push_data;
  logic                   pop;
  logic [DW-1:0]          head;

  erm_table_fill #(
    .ANGLE_BITS (ANGLE_BITS),
    .FRAC_BITS  (FRAC_BITS)
  ) u_fill (
    .clk     (clk),
    .rst     (rst),
    .fill    (fill),
    .wr_addr (wr_addr),
    .wr_data (wr_data)
  );

  erm_front #(
    .ANGLE_BITS (ANGLE_BITS),
    .FRAC_BITS  (FRAC_BITS)
  ) u_front (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_data   (in_data),
    .fill      (fill),
    .wr_addr   (wr_addr),
    .wr_data   (wr_data),
    .q_stat    (q_stat),
    .push      (push),
    .push_data (push_data)
  );

  erm_queue #(
    .DW (DW)
  ) u_queue (
    .clk       (clk),
    .rst       (rst),
    .push      (push),
    .push_data (push_data),
    .pop       (pop),
    .head      (head),
    .q_stat    (q_stat)
  );

  erm_back #(
    .FRAC_BITS (FRAC_BITS)
  ) u_back (
    .clk        (clk),
    .rst        (rst),
    .head_valid (q_stat.nonempty),
    .head_data  (head),
    .pop        (pop),
    .out_valid  (out_valid),
    .out_ready  (out_ready),
    .out_data   (out_data)
  );

  `ERM_ASSERT_NEXT(a_fill_sticky, fill.done, fill.done, "sine memory fill flag dropped")
  `ERM_ASSERT_IMPL(a_no_accept_in_fill, in_valid && in_ready, fill.done, "transaction during fill")
  `ERM_ASSERT_IMPL(a_queue_no_overflow, push && !pop, q_stat.count < QFULL, "queue overflow")
  `ERM_ASSERT_IMPL(a_pop_nonempty, pop, q_stat.count != '0, "pop from empty queue")

endmodule

// ===== hdl/erm_table_fill.sv =====
// quarter-wave sine table fill engine, multi-cycle series evaluation
// depends on erm_pkg
module erm_table_fill #(
  parameter int ANGLE_BITS = 16,
  parameter int FRAC_BITS  = 14
) (
  input  logic                     clk,
  input  logic                     rst,
  output erm_pkg::fill_ctl_t       fill,
  output logic [ANGLE_BITS-3:0]    wr_addr,
  output logic [FRAC_BITS:0]       wr_data
);
  import erm_pkg::*;

  localparam int KW = ANGLE_BITS - 2;
  localparam int TW = FRAC_BITS + 1;
  localparam int SH = 30 - FRAC_BITS;
  localparam logic [KW-1:0]  K_LAST  = '1;
  localparam logic [KW+31:0] ANG_RND = (KW+32)'(64'd1 << (KW - 1));
  localparam logic [34:0]    SUM_RND = (SH > 0) ? 35'(64'd1 << (SH - 1)) : 35'd0;
  localparam logic [TW-1:0]  T_ONE   = TW'(64'd1 << FRAC_BITS);

  fill_state_t state, state_next;

  logic [KW-1:0]      k;
  logic [30:0]        ang;
  logic [31:0]        ang2;
  logic [31:0]        term;
  logic [33:0]        x;
  logic [31:0]        quo;
  logic [33:0]        rem;
  logic signed [33:0] sum;
  logic [2:0]         step;

  logic [KW+31:0] ang_prod;
  logic [61:0]    sq_prod;
  logic [63:0]    term_prod;
  logic [65:0]    rec_prod;
  logic [33:0]    rem_calc;
  logic [33:0]    dvs;
  logic           fix_ge;
  logic [33:0]    sum_pos;
  logic [34:0]    rnd;
  logic [34:0]    t_full;
  logic [TW-1:0]  t_data;

  always_comb begin
    dvs       = 34'(divisor(step));
    ang_prod  = (KW+32)'(k) * (KW+32)'(HPI_Q30) + ANG_RND;
    sq_prod   = 62'(ang) * 62'(ang);
    term_prod = 64'(term) * 64'(ang2);
    rec_prod  = 66'(x) * 66'(recip(step));
    rem_calc  = x - 34'(quo) * dvs;
    fix_ge    = rem >= dvs;
    sum_pos   = sum[33] ? 34'd0 : sum;
    rnd       = 35'(sum_pos) + SUM_RND;
    t_full    = rnd >> SH;
    t_data    = (t_full > 35'(T_ONE)) ? T_ONE : TW'(t_full);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= FS_ANGLE;
      k     <= '0;
    end else begin
      state <= state_next;
      if ((state == FS_ANGLE && k == '0) || state == FS_ROUND) begin
        k <= k + 1'b1;
      end
    end
  end

  // series datapath
  always_ff @(posedge clk) begin
    case (state)
      FS_ANGLE: begin
        ang <= 31'(ang_prod >> KW);
      end
      FS_SQUARE: begin
        ang2 <= 32'(sq_prod >> 30);
        term <= 32'(ang);
        sum  <= $signed(34'(ang));
        step <= '0;
      end
      FS_TERM: begin
        x <= 34'(term_prod >> 30);
      end
      FS_RECIP: begin
        quo <= 32'(rec_prod >> 32);
      end
      FS_REMAIN: begin
        rem <= rem_calc;
      end
      FS_FIX: begin
        if (fix_ge) begin
          rem <= rem - dvs;
          quo <= quo + 32'd1;
        end else begin
          term <= quo;
          if (!step[0]) begin
            sum <= sum - $signed(34'(quo));
          end else begin
            sum <= sum + $signed(34'(quo));
          end
          step <= step + 3'd1;
        end
      end
      default: begin
      end
    endcase
  end

  always_comb begin
    state_next = state;
    case (state)
      FS_ANGLE:  state_next = (k == '0) ? FS_ANGLE : FS_SQUARE;
      FS_SQUARE: state_next = FS_TERM;
      FS_TERM:   state_next = FS_RECIP;
      FS_RECIP:  state_next = FS_REMAIN;
      FS_REMAIN: state_next = FS_FIX;
      FS_FIX: begin
        if (fix_ge) begin
          state_next = FS_FIX;
        end else if (step == 3'd7) begin
          state_next = FS_ROUND;
        end else begin
          state_next = FS_TERM;
        end
      end
      FS_ROUND:  state_next = (k == K_LAST) ? FS_DONE : FS_ANGLE;
      FS_DONE:   state_next = FS_DONE;
      default:   state_next = FS_ANGLE;
    endcase
  end

  always_comb begin
    fill.wr_en = 1'b0;
    fill.done  = 1'b0;
    wr_data    = '0;
    case (state)
      FS_ANGLE: begin
        // entry zero is sin(0), written without evaluation
        fill.wr_en = (k == '0);
      end
      FS_ROUND: begin
        fill.wr_en = 1'b1;
        wr_data    = t_data;
      end
      FS_DONE: begin
        fill.done = 1'b1;
      end
      default: begin
      end
    endcase
  end

  assign wr_addr = k;

endmodule

// ===== hdl/erm_front.sv =====
// front end: accepts angle transactions, looks up sine and cosine per axis
// depends on erm_pkg; table contents come from erm_table_fill
module erm_front #(
  parameter int ANGLE_BITS = 16,
  parameter int FRAC_BITS  = 14
) (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            in_valid,
  output logic                            in_ready,
  input  erm_pkg::erm_in_t                in_data,
  input  erm_pkg::fill_ctl_t              fill,
  input  logic [ANGLE_BITS-3:0]           wr_addr,
  input  logic [FRAC_BITS:0]              wr_data,
  input  erm_pkg::queue_stat_t            q_stat,
  output logic                            push,
  output logic [6*(FRAC_BITS+2)-1:0]      push_data
);
  import erm_pkg::*;

  localparam int AB = ANGLE_BITS;
  localparam int KW = ANGLE_BITS - 2;
  localparam int Q  = 1 << KW;
  localparam int TW = FRAC_BITS + 1;
  localparam int W  = FRAC_BITS + 2;
  localparam logic signed [W-1:0] ONE_W = W'(64'd1 << FRAC_BITS);

  logic                   v1;
  logic                   accept;
  logic [QCOUNT_BITS:0]   occ;
  logic [15:0]            ang_in [3];

  assign ang_in[0] = in_data.angle_x;
  assign ang_in[1] = in_data.angle_y;
  assign ang_in[2] = in_data.angle_z;

  // leave room in the queue for the lookup still in flight
  assign occ      = (QCOUNT_BITS+1)'(q_stat.count) + (QCOUNT_BITS+1)'(v1);
  assign in_ready = fill.done && (occ < (QCOUNT_BITS+1)'(QUEUE_DEPTH));
  assign accept   = in_valid && in_ready;
  assign push     = v1;

  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
    end else begin
      v1 <= accept;
    end
  end

  for (genvar l = 0; l < 3; l++) begin : g_lane
    logic [TW-1:0]       rom [Q];
    logic [AB-1:0]       phase;
    logic [KW-1:0]       a_lo;
    logic [KW-1:0]       a_hi;
    logic [TW-1:0]       rd_lo;
    logic [TW-1:0]       rd_hi;
    logic [1:0]          qd;
    logic                rzero;
    logic signed [W-1:0] lo;
    logic signed [W-1:0] hi;
    logic signed [W-1:0] sn;
    logic signed [W-1:0] cs;

    assign phase = AB'(ang_in[l]);
    assign a_lo  = phase[KW-1:0];
    assign a_hi  = KW'(0) - a_lo;

    always_ff @(posedge clk) begin
      if (fill.wr_en) begin
        rom[wr_addr] <= wr_data;
      end
      rd_lo <= rom[a_lo];
      rd_hi <= rom[a_hi];
      qd    <= phase[AB-1:AB-2];
      rzero <= (a_lo == '0);
    end

    // a zero remainder needs the full quarter, which is 1.0
    assign lo = $signed(W'(rd_lo));
    assign hi = rzero ? ONE_W : $signed(W'(rd_hi));

    always_comb begin
      case (qd)
        QD_FIRST: begin
          sn = lo;
          cs = hi;
        end
        QD_SECOND: begin
          sn = hi;
          cs = -lo;
        end
        QD_THIRD: begin
          sn = -lo;
          cs = -hi;
        end
        default: begin
          sn = -hi;
          cs = lo;
        end
      endcase
    end

    assign push_data[(2*l)*W +: W]   = sn;
    assign push_data[(2*l+1)*W +: W] = cs;
  end

endmodule

// ===== hdl/erm_queue.sv =====
// short fifo between front and back, register based
// depends on erm_pkg for depth and status type
module erm_queue #(
  parameter int DW = 96
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  push,
  input  logic [DW-1:0]         push_data,
  input  logic                  pop,
  output logic [DW-1:0]         head,
  output erm_pkg::queue_stat_t  q_stat
);
  import erm_pkg::*;

  logic [DW-1:0]          mem [QUEUE_DEPTH];
  logic [QPTR_BITS-1:0]   wr_ptr;
  logic [QPTR_BITS-1:0]   rd_ptr;
  logic [QCOUNT_BITS-1:0] count;
  logic [QCOUNT_BITS-1:0] count_next;

  always_comb begin
    case ({push, pop})
      2'b10:   count_next = count + 1'b1;
      2'b01:   count_next = count - 1'b1;
      default: count_next = count;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= rd_ptr + 1'b1;
      end
      count <= count_next;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      mem[wr_ptr] <= push_data;
    end
  end

  assign head            = mem[rd_ptr];
  assign q_stat.count    = count;
  assign q_stat.nonempty = (count != '0);

endmodule

// ===== hdl/erm_back.sv =====
// back end: products, sums and saturation of the nine matrix entries
// depends on erm_pkg; three stallable stages ending in the output register
module erm_back #(
  parameter int FRAC_BITS = 14
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          head_valid,
  input  logic [6*(FRAC_BITS+2)-1:0]    head_data,
  output logic                          pop,
  output logic                          out_valid,
  input  logic                          out_ready,
  output erm_pkg::erm_out_t             out_data
);
  import erm_pkg::*;

  localparam int W  = FRAC_BITS + 2;
  localparam int PW = 2 * W;
  localparam int EW = (W + 1 > 16) ? W + 1 : 16;
  localparam logic signed [PW-1:0] RND     = PW'(64'd1 << (FRAC_BITS - 1));
  localparam logic signed [W:0]    POS_ONE = (W+1)'(64'd1 << FRAC_BITS);
  localparam logic signed [W:0]    NEG_ONE = -POS_ONE;

  // product rounded half up, floor by arithmetic shift
  function automatic logic signed [W-1:0] fmul(input logic signed [W-1:0] a,
                                                input logic signed [W-1:0] b);
    logic signed [PW-1:0] ae;
    logic signed [PW-1:0] be;
    logic signed [PW-1:0] p;
    ae = PW'(a);
    be = PW'(b);
    p  = ae * be + RND;
    return W'(p >>> FRAC_BITS);
  endfunction

  function automatic logic signed [W:0] ext(input logic signed [W-1:0] a);
    return (W+1)'(a);
  endfunction

  function automatic logic signed [W:0] sat(input logic signed [W:0] v);
    logic signed [W:0] r;
    if (v > POS_ONE) begin
      r = POS_ONE;
    end else if (v < NEG_ONE) begin
      r = NEG_ONE;
    end else begin
      r = v;
    end
    return r;
  endfunction

  function automatic logic [15:0] pack(input logic signed [W:0] v);
    logic signed [EW-1:0] e;
    e = EW'(v);
    return e[15:0];
  endfunction

  logic signed [W-1:0] sx, cx, sy, cy, sz, cz;

  assign sx = $signed(head_data[0*W +: W]);
  assign cx = $signed(head_data[1*W +: W]);
  assign sy = $signed(head_data[2*W +: W]);
  assign cy = $signed(head_data[3*W +: W]);
  assign sz = $signed(head_data[4*W +: W]);
  assign cz = $signed(head_data[5*W +: W]);

  logic va, vb;
  logic ra, rb, ro;

  logic signed [W-1:0] a_sy, a_sz, a_cz;
  logic signed [W-1:0] a_czcy, a_szcx, a_szsx, a_szcy, a_czcx, a_czsx, a_cysx, a_cycx;
  logic signed [W-1:0] a_sysx, a_sycx;

  logic signed [W-1:0] b_sy;
  logic signed [W-1:0] b_czcy, b_szcx, b_szsx, b_szcy, b_czcx, b_czsx, b_cysx, b_cycx;
  logic signed [W-1:0] b_cz_sysx, b_cz_sycx, b_sz_sysx, b_sz_sycx;

  assign ro  = !out_valid || out_ready;
  assign rb  = !vb || ro;
  assign ra  = !va || rb;
  assign pop = head_valid && ra;

  always_ff @(posedge clk) begin
    if (rst) begin
      va        <= 1'b0;
      vb        <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      if (ra) begin
        va <= head_valid;
      end
      if (rb) begin
        vb <= va;
      end
      if (ro) begin
        out_valid <= vb;
      end
    end
  end

  // two-factor products
  always_ff @(posedge clk) begin
    if (ra) begin
      a_sy   <= sy;
      a_sz   <= sz;
      a_cz   <= cz;
      a_czcy <= fmul(cz, cy);
      a_szcx <= fmul(sz, cx);
      a_szsx <= fmul(sz, sx);
      a_szcy <= fmul(sz, cy);
      a_czcx <= fmul(cz, cx);
      a_czsx <= fmul(cz, sx);
      a_cysx <= fmul(cy, sx);
      a_cycx <= fmul(cy, cx);
      a_sysx <= fmul(sy, sx);
      a_sycx <= fmul(sy, cx);
    end
  end

  // three-factor terms, inner product first
  always_ff @(posedge clk) begin
    if (rb) begin
      b_sy      <= a_sy;
      b_czcy    <= a_czcy;
      b_szcx    <= a_szcx;
      b_szsx    <= a_szsx;
      b_szcy    <= a_szcy;
      b_czcx    <= a_czcx;
      b_czsx    <= a_czsx;
      b_cysx    <= a_cysx;
      b_cycx    <= a_cycx;
      b_cz_sysx <= fmul(a_cz, a_sysx);
      b_cz_sycx <= fmul(a_cz, a_sycx);
      b_sz_sysx <= fmul(a_sz, a_sysx);
      b_sz_sycx <= fmul(a_sz, a_sycx);
    end
  end

  always_ff @(posedge clk) begin
    if (ro) begin
      out_data.r0c0 <= pack(sat(ext(b_czcy)));
      out_data.r0c1 <= pack(sat(ext(b_szcx) + ext(b_cz_sysx)));
      out_data.r0c2 <= pack(sat(ext(b_szsx) - ext(b_cz_sycx)));
      out_data.r1c0 <= pack(sat(-ext(b_szcy)));
      out_data.r1c1 <= pack(sat(ext(b_czcx) - ext(b_sz_sysx)));
      out_data.r1c2 <= pack(sat(ext(b_czsx) + ext(b_sz_sycx)));
      out_data.r2c0 <= pack(sat(ext(b_sy)));
      out_data.r2c1 <= pack(sat(-ext(b_cysx)));
      out_data.r2c2 <= pack(sat(ext(b_cycx)));
    end
  end

endmodule
